// File: design/ffra_pkg.sv
// Shared sizes, field widths and status codes of the run allocator.
package ffra_pkg;

	localparam int POOLS     = 4;
	localparam int ROWS      = 8;
	localparam int ROW_SLOTS = 16;
	localparam int MAX_RUN   = 8;

	// request and response field widths
	localparam int OP_W      = 1;
	localparam int POOL_W    = 2;
	localparam int ROWIDX_W  = 3;
	localparam int ROWBITS_W = 16;
	localparam int LEN_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int FROW_W    = 3;
	localparam int FSLOT_W   = 4;

	// internal widths
	localparam int ENTRIES = POOLS * ROWS;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_W  = $clog2(ROW_SLOTS);

	localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

	localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFIT     = 2'd2;

endpackage

// File: design/ffra_req_if.sv
// Request channel of the run allocator: valid, ready and the request fields.
interface ffra_req_if;
	import ffra_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [POOL_W-1:0]    pool;
	logic [ROWIDX_W-1:0]  row_index;
	logic [ROWBITS_W-1:0] row_bits;
	logic [LEN_W-1:0]     run_length;

	modport source (output valid, output op, output pool, output row_index,
		output row_bits, output run_length, input ready);
	modport sink (input valid, input op, input pool, input row_index,
		input row_bits, input run_length, output ready);
endinterface

// File: design/ffra_rsp_if.sv
// Response channel of the run allocator: valid, ready and the result fields.
interface ffra_rsp_if;
	import ffra_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FROW_W-1:0]   found_row;
	logic [FSLOT_W-1:0]  first_slot;

	modport source (output valid, output status, output found_row,
		output first_slot, input ready);
	modport sink (input valid, input status, input found_row,
		input first_slot, output ready);
endinterface

// File: design/first_fit_run_allocator_core.sv
// First-fit run allocator: occupancy memory, row scan sequencer and result register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  req     | in  | valid / ready | op, pool, row_index, row_bits, run_length
//  rsp     | out | valid / ready | status, found_row, first_slot
//
// A load request, or an allocate with a bad pool or length, is answered at once:
// its result shows in the cycle after acceptance. A good allocate scans the pool's
// rows: one row word is read per cycle through a registered read, and the
// scan stops at the first row that holds a fit.
// Reset clears the per-entry valid bits at once, so no clearing pass is run. The
// result register holds until taken; a request is accepted while idle once it empties.
module first_fit_run_allocator_core (
	input  logic               clk,
	input  logic               arst_n,
	ffra_req_if.sink           req,
	ffra_rsp_if.source         rsp
);
	import ffra_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	// sequencer state
	logic               state_q;
	logic [ROW_W:0]     rd_row_q;
	logic [POOL_W-1:0]  pool_q;
	logic [LEN_W-1:0]   len_q;

	// occupancy memory and its valid bits
	logic [ROW_SLOTS-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0]   vld_q;

	// read pipeline
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [ROW_SLOTS-1:0] raw_s1;
	logic                 ent_vld_s1;
	logic [ROW_SLOTS-1:0] rd_word;

	// write port
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ROW_SLOTS-1:0] wr_data;

	// search
	logic [ROW_SLOTS-1:0] run_mask;
	logic                 hit;
	logic [SLOT_W-1:0]    hit_slot;

	// request decode
	logic                 accept;
	logic                 pool_ok;
	logic                 row_ok;
	logic                 len_ok;
	logic [ADDR_W-1:0]    load_addr;

	// result register
	logic                 res_set;
	logic [STATUS_W-1:0]  res_status;
	logic [FROW_W-1:0]    res_row;
	logic [FSLOT_W-1:0]   res_slot;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [FROW_W-1:0]    found_row_q;
	logic [FSLOT_W-1:0]   first_slot_q;

	logic                 scan_active;
	logic                 last_row_s1;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign pool_ok   = int'(req.pool) < POOLS;
	assign row_ok    = int'(req.row_index) < ROWS;
	assign len_ok    = (req.run_length != '0) && (int'(req.run_length) <= MAX_RUN)
		&& (int'(req.run_length) <= ROW_SLOTS);
	assign load_addr = ADDR_W'(int'(req.pool) * ROWS + int'(req.row_index));

	// Issue one row read per cycle until the last row has been requested.
	assign rd_en   = (state_q == S_SCAN) && (int'(rd_row_q) < ROWS);
	assign rd_addr = ADDR_W'(int'(pool_q) * ROWS + int'(rd_row_q[ROW_W-1:0]));

	// Never-written entries read as all free.
	assign rd_word = ent_vld_s1 ? raw_s1 : '0;

	assign run_mask = ~({ROW_SLOTS{1'b1}} << len_q);

	// Lowest start slot whose run is inside the row and entirely free.
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = ROW_SLOTS - 1; s >= 0; s--) begin
			if ((s + int'(len_q) <= ROW_SLOTS) && ((rd_word & (run_mask << s)) == '0)) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(s);
			end
		end
	end

	assign scan_active = (state_q == S_SCAN) && rd_s1;
	assign last_row_s1 = (row_s1 == ROW_W'(ROWS - 1));

	// Write port: a load writes its word; a hit writes the marked row back.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = load_addr;
		wr_data = ROW_SLOTS'(req.row_bits);
		if (accept && (req.op == OP_LOAD)) begin
			wr_en = pool_ok && row_ok;
		end else if (scan_active && hit) begin
			wr_en   = 1'b1;
			wr_addr = ADDR_W'(int'(pool_q) * ROWS + int'(row_s1));
			wr_data = rd_word | (run_mask << hit_slot);
		end
	end

	// Result selection.
	always_comb begin
		res_set    = 1'b0;
		res_status = ST_NOFIT;
		res_row    = '0;
		res_slot   = '0;
		if (accept) begin
			if (req.op == OP_LOAD) begin
				res_set    = 1'b1;
				res_status = ST_LOADED;
			end else if (!(pool_ok && len_ok)) begin
				res_set = 1'b1;
			end
		end else if (scan_active) begin
			if (hit) begin
				res_set    = 1'b1;
				res_status = ST_ALLOCATED;
				res_row    = FROW_W'(row_s1);
				res_slot   = FSLOT_W'(hit_slot);
			end else if (last_row_s1) begin
				res_set = 1'b1;
			end
		end
	end

	// Memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_s1     <= mem[rd_addr];
			ent_vld_s1 <= vld_q[rd_addr];
			row_s1     <= rd_row_q[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Sequencer: start a scan on a well-formed allocate, drop back on a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_row_q <= '0;
			rd_s1    <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req.op == OP_ALLOC) && pool_ok && len_ok) begin
						state_q  <= S_SCAN;
						rd_row_q <= '0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_row_q <= rd_row_q + 1'b1;
					end
					if (res_set) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pool_q <= req.pool;
			len_q  <= req.run_length;
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_set) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			status_q     <= res_status;
			found_row_q  <= res_row;
			first_slot_q <= res_slot;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.found_row  = found_row_q;
	assign rsp.first_slot = first_slot_q;

`ifndef NO_ASSERTIONS
	// A new result never lands on one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_set |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");

	// An allocated run lies entirely inside its row.
	a_run_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(res_set && (res_status == ST_ALLOCATED))
			|-> (int'(res_slot) + int'(len_q) <= ROW_SLOTS))
		else $error("allocated run crosses row end");

	// A scan always ends with a result before it runs out of rows.
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_active && last_row_s1) |-> res_set)
		else $error("scan finished without result");

	// No request is taken while a scan is in flight.
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !accept)
		else $error("request accepted during scan");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the first-fit run allocator: directed cases, back-pressure, random traffic.
module tb_top;
	import ffra_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [POOL_W-1:0]    pool;
		logic [ROWIDX_W-1:0]  row_index;
		logic [ROWBITS_W-1:0] row_bits;
		logic [LEN_W-1:0]     run_length;
	} alloc_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FROW_W-1:0]   found_row;
		logic [FSLOT_W-1:0]  first_slot;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	ffra_req_if req_ch();
	ffra_rsp_if rsp_ch();

	first_fit_run_allocator_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Bench copy of the occupancy bitmap, one row word per pool and row.
	logic [ROW_SLOTS-1:0] occ_map [POOLS][ROWS];

	// Grants (or refusals) still owed by the block, oldest first.
	alloc_rsp_t pending_grants[$];
	alloc_rsp_t oldest_grant;

	int mismatch_count = 0;
	int snd_idle_pct   = 0;
	int rsp_idle_pct   = 0;
	int rsp_hold_len   = 0;
	int rsp_hold_reqs  = 0;
	int rsp_hold_seen  = 0;
	int rsp_hold_left  = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Bail out if the block hangs; sized far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Apply one request to the bench bitmap and return the result the block owes.
	// Loads overwrite a row word; allocates scan rows in order and, inside a row,
	// start slots in order. A run must sit wholly inside one row.
	function automatic alloc_rsp_t predict_allocation(input alloc_req_t r);
		alloc_rsp_t           res;
		logic [ROW_SLOTS-1:0] run_mask;
		logic                 found;
		int                   len;
		int                   row;
		int                   slot;
		res.status     = ST_NOFIT;
		res.found_row  = '0;
		res.first_slot = '0;
		found          = 1'b0;
		len            = int'(r.run_length);
		if (r.op == OP_LOAD) begin
			res.status = ST_LOADED;
			// drop loads that address outside the array
			if (int'(r.pool) < POOLS && int'(r.row_index) < ROWS)
				occ_map[r.pool][r.row_index] = r.row_bits;
		end else if (int'(r.pool) < POOLS && len >= 1 && len <= MAX_RUN &&
				len <= ROW_SLOTS) begin
			run_mask = {ROW_SLOTS{1'b1}} >> (ROW_SLOTS - len);
			for (row = 0; row < ROWS && !found; row++) begin
				for (slot = 0; slot + len <= ROW_SLOTS && !found; slot++) begin
					if ((occ_map[r.pool][row] & (run_mask << slot)) == '0) begin
						occ_map[r.pool][row] = occ_map[r.pool][row] | (run_mask << slot);
						res.status     = ST_ALLOCATED;
						res.found_row  = row[FROW_W-1:0];
						res.first_slot = slot[FSLOT_W-1:0];
						found          = 1'b1;
					end
				end
			end
		end
		return res;
	endfunction

	function automatic alloc_req_t make_load(input int pool, input int row, input int bits);
		alloc_req_t r;
		r.op         = OP_LOAD;
		r.pool       = pool[POOL_W-1:0];
		r.row_index  = row[ROWIDX_W-1:0];
		r.row_bits   = bits[ROWBITS_W-1:0];
		r.run_length = LEN_W'($urandom_range((1 << LEN_W) - 1));
		return r;
	endfunction

	// Row index and row word ride along with allocates but must be ignored.
	function automatic alloc_req_t make_alloc(input int pool, input int len);
		alloc_req_t r;
		r.op         = OP_ALLOC;
		r.pool       = pool[POOL_W-1:0];
		r.row_index  = ROWIDX_W'($urandom_range((1 << ROWIDX_W) - 1));
		r.row_bits   = ROWBITS_W'($urandom);
		r.run_length = len[LEN_W-1:0];
		return r;
	endfunction

	// Mostly legal allocates against a bitmap that loads keep refreshing with
	// empty, full and sparse rows; a few lengths fall outside the legal range.
	function automatic alloc_req_t random_request();
		int pool;
		int pick;
		int bits;
		int len;
		pool = $urandom_range((1 << POOL_W) - 1);
		if ($urandom_range(99) < 35) begin
			pick = $urandom_range(99);
			if (pick < 30)
				bits = 0;
			else if (pick < 45)
				bits = (1 << ROWBITS_W) - 1;
			else if (pick < 75)
				bits = $urandom & $urandom;
			else
				bits = $urandom;
			return make_load(pool, $urandom_range((1 << ROWIDX_W) - 1), bits);
		end
		if ($urandom_range(99) < 85)
			len = $urandom_range(MAX_RUN, 1);
		else
			len = $urandom_range((1 << LEN_W) - 1);
		return make_alloc(pool, len);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Offer one request, idling at random first; return at the edge it is taken.
	// Valid stays high across back-to-back requests and is lowered only for a gap.
	task automatic send_request(input alloc_req_t r);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= r.op;
		req_ch.pool       <= r.pool;
		req_ch.row_index  <= r.row_index;
		req_ch.row_bits   <= r.row_bits;
		req_ch.run_length <= r.run_length;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_grants.push_back(predict_allocation(r));
	endtask

	// Response side: random stalls, plus long hold-offs counted here on request.
	always @(posedge clk) begin
		if (rsp_hold_reqs != rsp_hold_seen) begin
			rsp_hold_left = rsp_hold_len;
			rsp_hold_seen = rsp_hold_reqs;
		end
		if (rsp_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_left = rsp_hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Compare every taken result with the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result, status", 16'(rsp_ch.status), '0);
			end else begin
				oldest_grant = pending_grants.pop_front();
				if (rsp_ch.status !== oldest_grant.status)
					report_mismatch("status", 16'(rsp_ch.status),
						16'(oldest_grant.status));
				if (rsp_ch.found_row !== oldest_grant.found_row)
					report_mismatch("found_row", 16'(rsp_ch.found_row),
						16'(oldest_grant.found_row));
				if (rsp_ch.first_slot !== oldest_grant.first_slot)
					report_mismatch("first_slot", 16'(rsp_ch.first_slot),
						16'(oldest_grant.first_slot));
			end
		end
	end

	// Fresh pool 0: first fits pack into row 0, a long run spills to row 1,
	// then a shorter one fills the tail of row 0.
	task automatic test_basic_allocation();
		send_request(make_alloc(0, 1));
		send_request(make_alloc(0, MAX_RUN));
		send_request(make_alloc(0, MAX_RUN));
		send_request(make_alloc(0, 7));
	endtask

	// Zero length and lengths above the longest legal run are refused.
	task automatic test_rejected_lengths();
		send_request(make_alloc(1, 0));
		send_request(make_alloc(1, MAX_RUN + 1));
		send_request(make_alloc(1, (1 << LEN_W) - 1));
	endtask

	// Fill a whole pool, see it refuse, then free only the very last slot.
	task automatic test_full_pool();
		int row;
		for (row = 0; row < ROWS; row++)
			send_request(make_load(POOLS - 1, row, (1 << ROWBITS_W) - 1));
		send_request(make_alloc(POOLS - 1, 1));
		send_request(make_load(POOLS - 1, ROWS - 1, 'h7fff));
		send_request(make_alloc(POOLS - 1, 1));
	endtask

	// Free tail of one row next to free head of the next must not join;
	// a run ending on the last slot of a row must be found.
	task automatic test_row_boundary();
		send_request(make_load(2, 0, 'h0fff));
		send_request(make_load(2, 1, 'hfff0));
		send_request(make_alloc(2, 6));
		send_request(make_load(2, 0, 'h00ff));
		send_request(make_alloc(2, MAX_RUN));
	endtask

	// Hold results off for a long stretch while requests keep coming, so the
	// result register fills and the request side has to stall.
	task automatic test_backpressure();
		int n;
		snd_idle_pct  = 0;
		rsp_idle_pct  = 0;
		rsp_hold_len  = 80;
		rsp_hold_reqs = rsp_hold_reqs + 1;
		for (n = 0; n < 14; n++)
			send_request(random_request());
	endtask

	task automatic test_random_traffic(input int count, input int snd_pct, input int rsp_pct);
		int n;
		snd_idle_pct = snd_pct;
		rsp_idle_pct = rsp_pct;
		for (n = 0; n < count; n++)
			send_request(random_request());
	endtask

	initial begin
		int pool;
		int row;
		for (pool = 0; pool < POOLS; pool++)
			for (row = 0; row < ROWS; row++)
				occ_map[pool][row] = '0;
		// hold every input at a known value through reset
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_LOAD;
		req_ch.pool       = '0;
		req_ch.row_index  = '0;
		req_ch.row_bits   = '0;
		req_ch.run_length = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_allocation();
		test_rejected_lengths();
		test_full_pool();
		test_row_boundary();
		test_backpressure();
		test_random_traffic(215, 24, 45);
		test_random_traffic(215, 45, 24);
		test_random_traffic(210, 0, 0);

		// drain: wait for every owed result, then let the block go quiet
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (ROWS + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
